FILE: hw/rtl/aes_pkg.sv
// AES-128 package: item types, S-box function, round helpers.
// Used by the key schedule, round stage and top level.
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned KeyRegHigh = 0;
    localparam int unsigned KeyRegLow = 1;
    localparam int unsigned CfgIdxW = 1;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_item;

    typedef struct packed {
        logic stall;
        logic valid;
    } t_flow;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // round constant for round r (1..10), in the top byte
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] c;
        case (r)
            4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
            4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
            4'd9: c = 8'h1b; 4'd10: c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // one round-key step: previous 128-bit round key to the next
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] t, w0, w1, w2, w3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rcon(r), 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

FILE: hw/rtl/aes_key_sched.sv
// AES key schedule: expands the key one round key per cycle into registers.
// Depends on aes_pkg.
module aes_key_sched import aes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    output logic [127:0] o_rk [NumRounds+1]
);
    logic [127:0] r_rk [NumRounds+1];
    logic [3:0]   r_cnt;
    logic         r_busy;

    // one new round key each cycle after reset or a key write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd1;
            r_rk[0] <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd1;
            r_rk[0] <= i_key;
        end else if (r_busy) begin
            r_rk[r_cnt] <= next_key(r_rk[r_cnt - 4'd1], r_cnt);
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(NumRounds)) r_busy <= 1'b0;
        end
    end

    assign o_rk = r_rk;
endmodule

FILE: hw/rtl/aes_round.sv
// One AES round stage with its own valid register and stall.
// Depends on aes_pkg.
module aes_round import aes_pkg::*; #(
    parameter bit Last = 1'b0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_rk,
    input  logic         i_stall,
    output logic         o_valid,
    output logic [127:0] o_state
);
    logic [127:0] n_state, sh;
    logic [7:0]   s [16];
    logic [7:0]   m [16];
    logic         r_valid;
    logic [127:0] r_state;

    // SubBytes and ShiftRows, then MixColumns unless last, then AddRoundKey
    always_comb begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[4*c+r] = sbox(i_state[127 - 8*(4*((c+r)%4)+r) -: 8]);
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = s[4*c]   ^ (s[4*c]^s[4*c+1]^s[4*c+2]^s[4*c+3]) ^ xtime(s[4*c]^s[4*c+1]);
            m[4*c+1] = s[4*c+1] ^ (s[4*c]^s[4*c+1]^s[4*c+2]^s[4*c+3]) ^ xtime(s[4*c+1]^s[4*c+2]);
            m[4*c+2] = s[4*c+2] ^ (s[4*c]^s[4*c+1]^s[4*c+2]^s[4*c+3]) ^ xtime(s[4*c+2]^s[4*c+3]);
            m[4*c+3] = s[4*c+3] ^ (s[4*c]^s[4*c+1]^s[4*c+2]^s[4*c+3]) ^ xtime(s[4*c+3]^s[4*c]);
        end
        for (int i = 0; i < 16; i++)
            sh[127 - 8*i -: 8] = Last ? s[i] : m[i];
        n_state = sh ^ i_rk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
endmodule

FILE: hw/rtl/aes128_block_encrypt_unit.sv
// Top level: AES-128 ECB encryptor, 11-stage pipeline plus key schedule.
// Depends on aes_pkg, aes_key_sched, aes_round.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | i_in  (t_in_item)
//  out     | output    | o_valid / i_stall  | o_out (t_out_item)
//  cfg     | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Each item passes the initial key add stage and then ten round stages; one item
// per cycle when not stalled. The pipeline stalls as a whole on i_stall.
// After reset or a key write the schedule expands the key one round key per
// cycle; input stays stalled after a key write and after reset while the
// round keys are built, so no item is taken in that time.
module aes128_block_encrypt_unit import aes_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in_item            i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out_item           o_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);
    logic [63:0]  r_key_hi, r_key_lo;
    logic [127:0] rk [NumRounds+1];
    logic [NumRounds:0] v;
    logic [127:0] st [NumRounds+1];
    logic [3:0]   r_wait;
    logic         r_v0;
    logic [127:0] r_s0;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgIdxW'(KeyRegHigh): r_key_hi <= i_cfg_data;
                default:              r_key_lo <= i_cfg_data;
            endcase
        end
    end

    // expansion is started in the cycle after the register write
    logic r_kstart;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kstart <= 1'b0;
        else          r_kstart <= i_cfg_we;
    end

    aes_key_sched u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_kstart),
        .i_key({r_key_hi, r_key_lo}), .o_rk(rk)
    );

    // hold off input while keys are being built
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                r_wait <= 4'd12;
        else if (i_cfg_we)           r_wait <= 4'd13;
        else if (r_wait != 4'd0)     r_wait <= r_wait - 4'd1;
    end

    assign o_stall = i_stall || (r_wait != 4'd0) || i_cfg_we;

    // initial key add stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (!i_stall) r_v0 <= i_valid && !o_stall;
    end
    always_ff @(posedge i_clk) begin
        if (!i_stall) r_s0 <= {i_in.plain_high, i_in.plain_low} ^ rk[0];
    end

    assign v[0]  = r_v0;
    assign st[0] = r_s0;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
        aes_round #(.Last(g == NumRounds)) u_rnd (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(v[g-1]), .i_state(st[g-1]), .i_rk(rk[g]),
            .i_stall(i_stall), .o_valid(v[g]), .o_state(st[g])
        );
    end

    assign o_valid = v[NumRounds];
    assign o_out   = '{cipher_high: st[NumRounds][127:64], cipher_low: st[NumRounds][63:0]};

    // no item enters while the schedule is rebuilding
    a_no_accept_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != 4'd0) |-> o_stall) else $error("item accepted during key expansion");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result lost under stall");
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stall |-> o_stall) else $error("input taken while output stalled");
endmodule
